@@ rtl/spr_pkg.sv @@
// Shared types, codes and constants for the status packet receiver.
package spr_pkg;

    localparam int MAX_VALUE_BYTES = 4;
    localparam int VALUE_BYTES     = 4;
    localparam int COUNT_W         = 17;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 16;

    localparam logic [7:0]  HDR_FIRST    = 8'hFF;
    localparam logic [7:0]  HDR_THIRD    = 8'hFD;
    localparam logic [15:0] CRC_POLY     = 16'h8005;
    localparam logic [15:0] TIMEOUT_RST  = 16'd1000;
    localparam logic [2:0]  READ_LEN_RST = 3'd4;
    localparam logic [COUNT_W-1:0] HEADER_BYTES = COUNT_W'(7);
    localparam logic [COUNT_W-1:0] VALUE_OFFSET = COUNT_W'(9);
    localparam logic [15:0] MIN_LENGTH   = 16'd3;

    localparam logic [1:0] CMD_ARM  = 2'd0;
    localparam logic [1:0] CMD_BYTE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TIMEOUT    = 3'd1;
    localparam logic [2:0] ST_BAD_HEADER = 3'd2;
    localparam logic [2:0] ST_BAD_CRC    = 3'd3;
    localparam logic [2:0] ST_SHORT_LEN  = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_LENGTH   = 1'b1;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } t_spr_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
    } t_spr_out;

endpackage

@@ rtl/status_packet_receiver.sv @@
// Top level of the status packet receiver: input register, packet state and result register.
//
//   channel | direction | handshake                | payload
//   in      | input     | i_in_valid / o_in_stall  | i_in_data  (t_spr_in)
//   out     | output    | o_out_valid / i_out_stall| o_out_data (t_spr_out)
//   cfg     | input     | i_cfg_we                 | i_cfg_index, i_cfg_wdata
//
// A beat is accepted every cycle unless o_in_stall is high; it waits in the input register
// until it is processed, and its status beat is registered before it reaches the output.
// The byte CRC update is combinational: one beat per cycle while the output is not stalled.
// A stalled output holds its beat; the input register keeps taking beats until it
// holds one that cannot move on, and only then is o_in_stall raised.
// Reset is synchronous and active low; it disarms the receiver and loads the
// register defaults (timeout 1000 ticks, four value bytes).
module status_packet_receiver
    import spr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_spr_in                i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_spr_out               o_out_data,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic               r_in_valid;
    t_spr_in            r_in;
    logic               r_out_valid;
    t_spr_out           r_out;

    logic [15:0]        r_timeout;
    logic [2:0]         r_read_len;

    logic               r_armed,      n_armed;
    logic [COUNT_W-1:0] r_count,      n_count;
    logic               r_hdr_ok,     n_hdr_ok;
    logic [15:0]        r_len,        n_len;
    logic [15:0]        r_crc,        n_crc;
    logic [15:0]        r_wait,       n_wait;
    logic [31:0]        r_value,      n_value;
    logic [7:0]         r_crc_low,    n_crc_low;

    logic               out_free;
    logic               advance;
    logic               in_take;
    logic               res_valid;
    t_spr_out           res;
    logic [15:0]        crc_next;
    logic [3:0]         eff_len;
    logic [COUNT_W-1:0] crc_end;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    spr_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (r_in.rx_byte),
        .o_crc  (crc_next)
    );

    assign eff_len = ({1'b0, r_read_len} > 4'(MAX_VALUE_BYTES)) ?
                     4'(MAX_VALUE_BYTES) : {1'b0, r_read_len};
    // Index of the low CRC byte: length + 7 - 2.
    assign crc_end = {1'b0, r_len} + HEADER_BYTES - COUNT_W'(2);

    always_comb begin
        n_armed   = r_armed;
        n_count   = r_count;
        n_hdr_ok  = r_hdr_ok;
        n_len     = r_len;
        n_crc     = r_crc;
        n_wait    = r_wait;
        n_value   = r_value;
        n_crc_low = r_crc_low;
        res_valid = 1'b0;
        res       = '{status: ST_OK, value: 32'd0};

        if (advance) begin
            case (r_in.command)
                CMD_ARM: begin
                    n_armed   = 1'b1;
                    n_count   = '0;
                    n_hdr_ok  = 1'b1;
                    n_len     = '0;
                    n_crc     = '0;
                    n_wait    = '0;
                    n_value   = '0;
                    n_crc_low = '0;
                end
                CMD_BYTE: begin
                    if (r_armed) begin
                        n_wait = '0;
                        if (r_count == COUNT_W'(0) || r_count == COUNT_W'(1)) begin
                            if (r_in.rx_byte != HDR_FIRST) n_hdr_ok = 1'b0;
                        end else if (r_count == COUNT_W'(2)) begin
                            if (r_in.rx_byte != HDR_THIRD) n_hdr_ok = 1'b0;
                        end else if (r_count == COUNT_W'(5)) begin
                            n_len = {8'h00, r_in.rx_byte};
                        end else if (r_count == COUNT_W'(6)) begin
                            n_len = {r_in.rx_byte, r_len[7:0]};
                        end

                        for (int k = 0; k < VALUE_BYTES; k++) begin
                            if (r_count == VALUE_OFFSET + COUNT_W'(k) && 4'(k) < eff_len) begin
                                n_value[8*k +: 8] = r_value[8*k +: 8] | r_in.rx_byte;
                            end
                        end

                        if (r_count < HEADER_BYTES) begin
                            n_crc   = crc_next;
                            n_count = r_count + COUNT_W'(1);
                            if (r_count == HEADER_BYTES - COUNT_W'(1)) begin
                                if (!n_hdr_ok) begin
                                    res_valid  = 1'b1;
                                    res.status = ST_BAD_HEADER;
                                end else if (n_len < MIN_LENGTH) begin
                                    res_valid  = 1'b1;
                                    res.status = ST_SHORT_LEN;
                                end
                            end
                        end else if (r_count < crc_end) begin
                            n_crc   = crc_next;
                            n_count = r_count + COUNT_W'(1);
                        end else if (r_count == crc_end) begin
                            n_crc_low = r_in.rx_byte;
                            n_count   = r_count + COUNT_W'(1);
                        end else begin
                            res_valid = 1'b1;
                            if (r_crc_low == r_crc[7:0] && r_in.rx_byte == r_crc[15:8]) begin
                                res.status = ST_OK;
                                res.value  = n_value;
                            end else begin
                                res.status = ST_BAD_CRC;
                            end
                        end
                    end
                end
                CMD_TICK: begin
                    // The body is not timed: ticks count only while the header arrives.
                    if (r_armed && r_count < HEADER_BYTES) begin
                        if (r_wait >= r_timeout) begin
                            res_valid  = 1'b1;
                            res.status = ST_TIMEOUT;
                        end else begin
                            n_wait = r_wait + 16'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (res_valid) begin
                n_armed = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_timeout   <= TIMEOUT_RST;
            r_read_len  <= READ_LEN_RST;
            r_armed     <= 1'b0;
            r_count     <= '0;
            r_hdr_ok    <= 1'b1;
            r_len       <= '0;
            r_crc       <= '0;
            r_wait      <= '0;
            r_value     <= '0;
            r_crc_low   <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TIMEOUT_TICKS: r_timeout  <= i_cfg_wdata;
                    CFG_READ_LENGTH:   r_read_len <= i_cfg_wdata[2:0];
                    default: begin
                    end
                endcase
            end

            r_armed   <= n_armed;
            r_count   <= n_count;
            r_hdr_ok  <= n_hdr_ok;
            r_len     <= n_len;
            r_crc     <= n_crc;
            r_wait    <= n_wait;
            r_value   <= n_value;
            r_crc_low <= n_crc_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

endmodule

@@ rtl/spr_crc_byte.sv @@
// One-byte update of the non-reflected CRC-16 with polynomial 0x8005.
module spr_crc_byte
    import spr_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {i_byte, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

@@ rtl/spr_checker.sv @@
// Port-level checks for the status packet receiver and the bind that attaches them.
module spr_port_checks
    import spr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     o_in_stall,
    input  logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_spr_out o_out_data
);

    // A held output beat does not change while the sink stalls it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // Input back-pressure only comes from a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled output beat");

    // Error statuses always carry a zero value.
    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.value == 32'd0)
        else $error("non-zero value with an error status");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= ST_SHORT_LEN)
        else $error("status code out of range");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind status_packet_receiver spr_port_checks u_spr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

@@ tb/spr_checker.sv @@
// Checker for the status packet receiver: tracks accepted beats, predicts status beats and compares.
module spr_checker
    import spr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  t_spr_in                i_in_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  t_spr_out               i_out_data,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0]        tmo_cfg;
    logic [2:0]         rlen_cfg;

    bit                 rx_armed;
    logic [COUNT_W-1:0] rx_count;
    bit                 hdr_ok;
    logic [15:0]        frame_len;
    logic [15:0]        crc_acc;
    logic [15:0]        tick_wait;
    logic [31:0]        value_acc;
    logic [7:0]         crc_lo_rx;

    t_spr_out           status_q[$];
    t_spr_out           want;
    int                 fails = 0;
    int                 checked = 0;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = crc ^ {b, 8'h00};
        for (k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    task automatic clear_frame();
        rx_count  = '0;
        hdr_ok    = 1'b1;
        frame_len = '0;
        crc_acc   = '0;
        tick_wait = '0;
        value_acc = '0;
        crc_lo_rx = '0;
    endtask

    task automatic close_frame(input logic [2:0] status, input logic [31:0] value);
        t_spr_out res;
        res.status = status;
        res.value  = value;
        status_q.push_back(res);
        rx_armed = 1'b0;
    endtask

    task automatic take_byte(input logic [7:0] b);
        int unsigned idx;
        int unsigned total;
        int unsigned eff;
        int unsigned vi;
        tick_wait = '0;
        idx       = rx_count;
        total     = int'(frame_len) + 7;

        if (idx == 0 || idx == 1) begin
            if (b != HDR_FIRST) hdr_ok = 1'b0;
        end else if (idx == 2) begin
            if (b != HDR_THIRD) hdr_ok = 1'b0;
        end else if (idx == 5) begin
            frame_len = {8'h00, b};
        end else if (idx == 6) begin
            frame_len[15:8] = b;
        end

        eff = (rlen_cfg > MAX_VALUE_BYTES) ? MAX_VALUE_BYTES : rlen_cfg;
        if (idx >= VALUE_OFFSET) begin
            vi = idx - VALUE_OFFSET;
            if (vi < eff && vi < VALUE_BYTES) value_acc[8*vi +: 8] = b;
        end

        if (idx < HEADER_BYTES) begin
            crc_acc  = crc16_byte(crc_acc, b);
            rx_count = COUNT_W'(idx + 1);
            // Header and length are judged together once the seventh byte is in.
            if (rx_count == HEADER_BYTES) begin
                if (!hdr_ok) close_frame(ST_BAD_HEADER, '0);
                else if (frame_len < MIN_LENGTH) close_frame(ST_SHORT_LEN, '0);
            end
        end else if (idx < total - 2) begin
            crc_acc  = crc16_byte(crc_acc, b);
            rx_count = COUNT_W'(idx + 1);
        end else if (idx == total - 2) begin
            crc_lo_rx = b;
            rx_count  = COUNT_W'(idx + 1);
        end else if (crc_lo_rx == crc_acc[7:0] && b == crc_acc[15:8]) begin
            close_frame(ST_OK, value_acc);
        end else begin
            close_frame(ST_BAD_CRC, '0);
        end
    endtask

    task automatic predict_beat(input t_spr_in beat);
        case (beat.command)
            CMD_ARM: begin
                clear_frame();
                rx_armed = 1'b1;
            end
            CMD_BYTE: begin
                if (rx_armed) take_byte(beat.rx_byte);
            end
            CMD_TICK: begin
                // Only the header bytes are timed.
                if (rx_armed && rx_count < HEADER_BYTES) begin
                    if (tick_wait >= tmo_cfg) close_frame(ST_TIMEOUT, '0);
                    else tick_wait = tick_wait + 16'd1;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tmo_cfg  = TIMEOUT_RST;
            rlen_cfg = READ_LEN_RST;
            rx_armed = 1'b0;
            clear_frame();
            status_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TIMEOUT_TICKS: tmo_cfg  = i_cfg_wdata;
                    CFG_READ_LENGTH:   rlen_cfg = i_cfg_wdata[2:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected status beat: status %0d value %h",
                             $time, i_out_data.status, i_out_data.value);
                end else begin
                    want = status_q.pop_front();
                    checked++;
                    if (want.status !== i_out_data.status) begin
                        fails++;
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, i_out_data.status);
                    end
                    if (want.value !== i_out_data.value) begin
                        fails++;
                        $display("%0t: value mismatch: expected %h, got %h",
                                 $time, want.value, i_out_data.value);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_beat(i_in_data);
        end
        o_pending    <= status_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the status packet receiver: clock, reset, packet stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import spr_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         HOLD_CYCLES    = 400;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    t_spr_in                in_data   = '0;
    logic                   out_stall = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   in_stall;
    logic                   out_valid;
    t_spr_out               out_data;

    int          fail_count;
    int          pending;
    int          checked;
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    bit          hold_req      = 1'b0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;
    int          beats_sent    = 0;
    logic [15:0] cur_tmo       = TIMEOUT_RST;
    logic [7:0]  frame_bytes[$];

    status_packet_receiver dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    spr_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #1 clk = ~clk;

    // Output side: random stalls, or one long hold when requested.
    always @(posedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d status beats outstanding",
                     $time, WATCHDOG_LIMIT, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = crc ^ {b, 8'h00};
        for (k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{command: cmd, rx_byte: data};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(CMD_TICK, 8'($urandom));
    endtask

    // Builds a well-formed packet with the given length field and random contents.
    task automatic build_frame(input int len);
        logic [15:0] crc;
        frame_bytes.delete();
        frame_bytes.push_back(HDR_FIRST);
        frame_bytes.push_back(HDR_FIRST);
        frame_bytes.push_back(HDR_THIRD);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(len[7:0]);
        frame_bytes.push_back(len[15:8]);
        repeat (len - 2) frame_bytes.push_back(8'($urandom));
        crc = '0;
        foreach (frame_bytes[i]) crc = crc16_next(crc, frame_bytes[i]);
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
    endtask

    // Header bytes may be preceded by up to the allowed number of ticks; body ticks are ignored.
    task automatic send_frame_range(input int first, input int count);
        for (int i = first; i < first + count; i++) begin
            if (i < 7 && $urandom_range(0, 3) == 0) begin
                send_ticks($urandom_range(0, (cur_tmo < 4) ? cur_tmo : 4));
            end else if (i >= 7 && $urandom_range(0, 19) == 0) begin
                send_ticks($urandom_range(1, 3));
            end
            send_item(CMD_BYTE, frame_bytes[i]);
        end
    endtask

    task automatic random_frame();
        int len;
        int pick;
        int pos;
        pick = $urandom_range(0, 99);
        if (pick < 85) len = $urandom_range(3, 14);
        else if (pick < 98) len = $urandom_range(15, 60);
        else len = $urandom_range(250, 300);
        build_frame(len);
        send_item(CMD_ARM, 8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            pos = $urandom_range(0, 2);
            frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
            send_frame_range(0, 7);
        end else if (pick < 16) begin
            frame_bytes[5] = 8'($urandom_range(0, 2));
            frame_bytes[6] = 8'h00;
            send_frame_range(0, 7);
        end else if (pick < 24) begin
            pos = frame_bytes.size() - 1 - $urandom_range(0, 1);
            frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
            send_frame_range(0, frame_bytes.size());
        end else if (pick < 30 && cur_tmo <= 64) begin
            send_frame_range(0, $urandom_range(0, 6));
            send_ticks(cur_tmo + 1);
        end else if (pick < 36) begin
            // Cut short; the next packet re-arms the receiver mid-reception.
            send_frame_range(0, $urandom_range(1, frame_bytes.size() - 1));
        end else if (pick < 42) begin
            repeat ($urandom_range(1, 8)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
        end else begin
            send_frame_range(0, frame_bytes.size());
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] tmo, input logic [2:0] rlen);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIMEOUT_TICKS;
        cfg_wdata <= tmo;
        @(posedge clk);
        cfg_index <= CFG_READ_LENGTH;
        cfg_wdata <= {13'd0, rlen};
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_tmo = tmo;
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input logic [15:0] tmo,
                             input logic [2:0] rlen, input int beats, input bit with_hold);
        int stop_at;
        drain();
        set_config(tmo, rlen);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        if (with_hold) hold_req = 1'b1;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) random_frame();
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config(16'd1, 3'd4);

        // Traffic while disarmed and the unused command code are all ignored.
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_TICK, 8'hFF);
        send_item(CMD_UNUSED, 8'hFF);

        // With a one-tick budget the second tick after arming times out.
        send_item(CMD_ARM, 8'h00);
        send_ticks(2);

        // Re-arm mid-header, then the shortest legal packet; its value byte is the CRC high byte.
        build_frame(3);
        send_item(CMD_ARM, 8'h00);
        send_item(CMD_BYTE, HDR_FIRST);
        send_item(CMD_ARM, 8'hFF);
        send_frame_range(0, 7);
        send_item(CMD_TICK, 8'h00);
        send_frame_range(7, frame_bytes.size() - 7);

        run_phase(23, 71, 16'd3,     3'd1, 320, 1'b1);
        run_phase(23, 71, 16'd65535, 3'd4, 320, 1'b0);
        run_phase(71, 23, 16'd2,     3'd2, 320, 1'b0);
        run_phase(71, 23, 16'd1,     3'd3, 320, 1'b0);
        run_phase(0,  0,  16'd5,     3'd4, 320, 1'b0);
        run_phase(0,  0,  16'd40,    3'd1, 320, 1'b0);
        drain();

        $display("Sent %0d input beats over six timeout and value-width settings;", beats_sent);
        $display("compared %0d status beats under three stall patterns and a long output hold.",
                 checked);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ status_packet_receiver.f @@
rtl/spr_pkg.sv
rtl/spr_crc_byte.sv
rtl/status_packet_receiver.sv
rtl/spr_checker.sv
tb/spr_checker.sv
tb/tb_top.sv
